FILE: src/sppsc_pkg.sv
// ----------------------------------------------------------------------------
// Sustain pedal phase scheduler package
// Shared constants, queue types and phase codes.
// ----------------------------------------------------------------------------
package sppsc_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	typedef logic [31:0] time_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam cnt_t CNT_ONE = cnt_t'(1);
	localparam cnt_t CNT_TWO = cnt_t'(2);
	localparam cnt_t CNT_FULL = cnt_t'(QUEUE_DEPTH);

	localparam logic [1:0] PH_DEACT = 2'd0;
	localparam logic [1:0] PH_OFF = 2'd1;
	localparam logic [1:0] PH_ACT = 2'd2;
	localparam logic [1:0] PH_ON = 2'd3;

	typedef struct packed {
		logic push;
		time_t push_data;
		logic ovw;
		time_t ovw_data;
		logic drop;
		logic trunc;
	} q_ctl_t;

	typedef struct packed {
		time_t entry1;
		time_t newest;
		cnt_t count;
	} q_sts_t;

endpackage

FILE: src/sppsc_queue.sv
// ----------------------------------------------------------------------------
// Sustain pedal phase queue
// Timestamp queue whose first entry is the last fired time of the phase.
// ----------------------------------------------------------------------------
module sppsc_queue import sppsc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cnt_t rst_count,
	input q_ctl_t ctl,
	output q_sts_t sts
);

	time_t ent_q [QUEUE_DEPTH];
	cnt_t cnt_q;
	cnt_t cnt_m1;
	logic [IDX_W-1:0] push_idx;
	logic [IDX_W-1:0] new_idx;
	logic full;

	assign cnt_m1 = cnt_q - CNT_ONE;
	assign push_idx = cnt_q[IDX_W-1:0];
	assign new_idx = cnt_m1[IDX_W-1:0];
	assign full = (cnt_q == CNT_FULL);

	assign sts.entry1 = ent_q[1];
	assign sts.newest = ent_q[new_idx];
	assign sts.count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= rst_count;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				ent_q[i] <= '0;
			end
		end else if (ctl.trunc) begin
			cnt_q <= ctl.push ? CNT_TWO : CNT_ONE;
			if (ctl.push) begin
				ent_q[1] <= ctl.push_data;
			end
		end else if (ctl.drop) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				ent_q[i] <= ent_q[i+1];
			end
			cnt_q <= cnt_m1;
		end else begin
			if (ctl.push && !full) begin
				ent_q[push_idx] <= ctl.push_data;
				cnt_q <= cnt_q + CNT_ONE;
			end
			if (ctl.ovw) begin
				ent_q[new_idx] <= ctl.ovw_data;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 && cnt_q <= CNT_FULL)
		else $error("queue count out of range");

	a_drop_pending: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.drop && !ctl.trunc |-> cnt_q > CNT_ONE)
		else $error("drop without pending entry");

	a_drop_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.drop && !ctl.trunc |=> cnt_q == $past(cnt_q) - CNT_ONE)
		else $error("drop did not shrink queue");

endmodule

FILE: src/sppsc_alu.sv
// ----------------------------------------------------------------------------
// Sustain pedal shared arithmetic unit
// One 32-bit adder/subtractor and one unsigned compare, reused each step.
// ----------------------------------------------------------------------------
module sppsc_alu import sppsc_pkg::*; (
	input time_t add_a,
	input time_t add_b,
	input logic sub,
	input time_t cmp_x,
	input time_t cmp_y,
	output time_t sum,
	output logic ge
);

	assign sum = sub ? (add_a - add_b) : (add_a + add_b);
	assign ge = (cmp_x >= cmp_y);

endmodule

FILE: src/sustain_pedal_phase_scheduler_core.sv
// ----------------------------------------------------------------------------
// Sustain pedal phase scheduler core
// Sequencer over four phase queues and a shared add/compare unit.
// ----------------------------------------------------------------------------
// A pedal event (cmd 0) runs from the accept cycle through six sequencer
// steps until busy goes low; it gives no result. A tick (cmd 1) runs from
// the accept cycle through two steps per phase transition, one per timeout
// and one to flush; all steps share the single adder/comparator. Results come
// at most one per cycle on result_valid, each held back until the next one is
// known, with last marking the final one of the tick in the same cycle that busy
// falls; the receiver cannot stall, so every strobe must be taken.
// Configuration writes take effect at once and belong in idle time.
module sustain_pedal_phase_scheduler_core import sppsc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cmd,
	input logic [6:0] velocity,
	input logic [31:0] now_ms,
	output logic result_valid,
	output logic [7:0] pwm_value,
	output logic last,
	input logic wr_en,
	input logic [2:0] wr_index,
	input logic [31:0] wr_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EV_T = 4'd1;
	localparam logic [3:0] S_EV_A = 4'd2;
	localparam logic [3:0] S_EV_B = 4'd3;
	localparam logic [3:0] S_EV_C = 4'd4;
	localparam logic [3:0] S_EV_D = 4'd5;
	localparam logic [3:0] S_EV_ACT = 4'd6;
	localparam logic [3:0] S_TK_NOW = 4'd7;
	localparam logic [3:0] S_TK_ORD = 4'd8;
	localparam logic [3:0] S_TO_ACT = 4'd9;
	localparam logic [3:0] S_TO_ON = 4'd10;
	localparam logic [3:0] S_FIN = 4'd11;

	localparam logic [2:0] REG_THRESH = 3'd0;
	localparam logic [2:0] REG_LEAD = 3'd1;
	localparam logic [2:0] REG_ON_TRAVEL = 3'd2;
	localparam logic [2:0] REG_OFF_TRAVEL = 3'd3;
	localparam logic [2:0] REG_TIMEOUT = 3'd4;
	localparam logic [2:0] REG_PWM_OFF = 3'd5;
	localparam logic [2:0] REG_PWM_ON = 3'd6;
	localparam logic [2:0] REG_PWM_HOLD = 3'd7;

	logic [6:0] thresh_q;
	logic [15:0] lead_q;
	logic [15:0] on_trav_q;
	logic [15:0] off_trav_q;
	time_t timeout_q;
	logic [7:0] pwm_off_q;
	logic [7:0] pwm_on_q;
	logic [7:0] pwm_hold_q;

	logic [3:0] state_q;
	logic [1:0] pair_q;
	logic [6:0] vel_q;
	time_t now_q;
	time_t t_q;
	time_t a_q;
	time_t b_q;
	time_t c_q;
	time_t d_q;
	logic f_off_q;
	logic f_act_q;
	logic f_sq_q;
	logic f_now_q;
	time_t act_time_q;
	logic [7:0] req_q;
	logic pend_v_q;
	logic [7:0] pend_val_q;
	logic result_valid_q;
	logic [7:0] pwm_value_q;
	logic last_q;

	q_ctl_t ctl [4];
	q_sts_t sts [4];

	time_t add_a;
	time_t add_b;
	logic add_sub;
	time_t cmp_x;
	time_t cmp_y;
	time_t sum;
	logic ge;

	logic [1:0] later;
	logic fire;
	logic sched_rst;
	logic emit_v;
	logic [7:0] emit_val;
	logic [7:0] pair_pwm;

	for (genvar p = 0; p < 4; p++) begin : g_queue
		sppsc_queue u_queue (
			.clk (clk),
			.arst_n (arst_n),
			.rst_count ((p == int'(PH_OFF)) ? CNT_TWO : CNT_ONE),
			.ctl (ctl[p]),
			.sts (sts[p])
		);
	end

	sppsc_alu u_alu (
		.add_a (add_a),
		.add_b (add_b),
		.sub (add_sub),
		.cmp_x (cmp_x),
		.cmp_y (cmp_y),
		.sum (sum),
		.ge (ge)
	);

	assign later = pair_q + 2'd1;
	assign busy = (state_q != S_IDLE);
	assign result_valid = result_valid_q;
	assign pwm_value = pwm_value_q;
	assign last = last_q;

	always_comb begin
		case (pair_q)
			2'd0: pair_pwm = pwm_off_q;
			2'd1: pair_pwm = pwm_on_q;
			2'd2: pair_pwm = pwm_hold_q;
			default: pair_pwm = pwm_off_q;
		endcase
	end

	always_comb begin
		add_a = t_q;
		add_b = '0;
		add_sub = 1'b0;
		cmp_x = now_q;
		cmp_y = sum;
		unique case (state_q)
			S_EV_T: begin
				add_a = now_q;
				add_b = time_t'(lead_q);
			end
			S_EV_A: begin
				add_b = time_t'(off_trav_q);
				add_sub = 1'b1;
			end
			S_EV_B: begin
				add_b = time_t'(on_trav_q);
				add_sub = 1'b1;
				cmp_x = a_q;
				cmp_y = sts[PH_ON].newest;
			end
			S_EV_C: begin
				add_a = a_q;
				add_b = time_t'(on_trav_q);
				add_sub = 1'b1;
				cmp_x = b_q;
				cmp_y = sts[PH_OFF].newest;
			end
			S_EV_D: begin
				add_b = time_t'(off_trav_q);
				cmp_x = c_q;
				cmp_y = sts[PH_ON].newest;
			end
			S_TK_NOW: begin
				cmp_y = sts[later].entry1;
			end
			S_TK_ORD: begin
				cmp_x = sts[later].entry1;
				cmp_y = sts[pair_q].entry1;
			end
			S_TO_ACT: begin
				add_a = act_time_q;
				add_b = timeout_q;
			end
			S_TO_ON: begin
				add_a = sts[PH_ON].entry1;
				add_b = timeout_q;
			end
			default: begin
			end
		endcase
	end

	assign fire = (state_q == S_TK_ORD) && f_now_q && ge &&
		(sts[later].count > CNT_ONE) && (sts[pair_q].count > CNT_ONE);
	assign sched_rst = ((state_q == S_TO_ACT) && (act_time_q != '0) && ge) ||
		((state_q == S_TO_ON) && (sts[PH_ON].count > CNT_ONE) && ge);
	assign emit_v = fire || sched_rst;
	assign emit_val = fire ? pair_pwm : pwm_off_q;

	always_comb begin
		for (int p = 0; p < 4; p++) begin
			ctl[p] = '0;
			ctl[p].trunc = sched_rst;
		end
		ctl[PH_OFF].push = sched_rst;
		ctl[PH_OFF].push_data = now_q;
		if (fire) begin
			ctl[pair_q].drop = 1'b1;
		end
		if (state_q == S_EV_ACT) begin
			if (vel_q < thresh_q) begin
				if (req_q != '0) begin
					ctl[PH_DEACT].push = 1'b1;
					ctl[PH_OFF].push = 1'b1;
					ctl[PH_DEACT].push_data = f_off_q ? a_q : t_q;
					ctl[PH_OFF].push_data = f_off_q ? t_q : d_q;
				end
			end else if (req_q == '0) begin
				if (f_act_q) begin
					ctl[PH_ACT].push = 1'b1;
					ctl[PH_ACT].push_data = b_q;
					ctl[PH_ON].push = 1'b1;
					ctl[PH_ON].push_data = t_q;
				end else if (f_sq_q) begin
					ctl[PH_DEACT].ovw = 1'b1;
					ctl[PH_DEACT].ovw_data = c_q;
					ctl[PH_OFF].ovw = 1'b1;
					ctl[PH_OFF].ovw_data = b_q;
					ctl[PH_ACT].push = 1'b1;
					ctl[PH_ACT].push_data = a_q;
					ctl[PH_ON].push = 1'b1;
					ctl[PH_ON].push_data = t_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= 7'd64;
			lead_q <= 16'd500;
			on_trav_q <= 16'd100;
			off_trav_q <= 16'd100;
			timeout_q <= 32'd30000;
			pwm_off_q <= 8'd0;
			pwm_on_q <= 8'd255;
			pwm_hold_q <= 8'd128;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_THRESH: thresh_q <= wr_data[6:0];
				REG_LEAD: lead_q <= wr_data[15:0];
				REG_ON_TRAVEL: on_trav_q <= wr_data[15:0];
				REG_OFF_TRAVEL: off_trav_q <= wr_data[15:0];
				REG_TIMEOUT: timeout_q <= wr_data;
				REG_PWM_OFF: pwm_off_q <= wr_data[7:0];
				REG_PWM_ON: pwm_on_q <= wr_data[7:0];
				REG_PWM_HOLD: pwm_hold_q <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					vel_q <= velocity;
					now_q <= now_ms;
				end
			end
			S_EV_T: t_q <= sum;
			S_EV_A: a_q <= sum;
			S_EV_B: begin
				b_q <= sum;
				f_off_q <= ge;
			end
			S_EV_C: begin
				c_q <= sum;
				f_act_q <= ge;
			end
			S_EV_D: begin
				d_q <= sum;
				f_sq_q <= ge;
			end
			S_TK_NOW: f_now_q <= ge;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pair_q <= '0;
			act_time_q <= '0;
			req_q <= '0;
			pend_v_q <= 1'b0;
			pend_val_q <= '0;
			result_valid_q <= 1'b0;
			pwm_value_q <= '0;
			last_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			last_q <= 1'b0;
			if (emit_v) begin
				pend_v_q <= 1'b1;
				pend_val_q <= emit_val;
				if (pend_v_q) begin
					result_valid_q <= 1'b1;
					pwm_value_q <= pend_val_q;
				end
			end
			if (sched_rst) begin
				act_time_q <= '0;
				req_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						pair_q <= '0;
						state_q <= cmd ? S_TK_NOW : S_EV_T;
					end
				end
				S_EV_T: state_q <= S_EV_A;
				S_EV_A: state_q <= S_EV_B;
				S_EV_B: state_q <= S_EV_C;
				S_EV_C: state_q <= S_EV_D;
				S_EV_D: state_q <= S_EV_ACT;
				S_EV_ACT: begin
					if (vel_q < thresh_q) begin
						if (req_q != '0) begin
							req_q <= '0;
						end
					end else if (req_q == '0 && (f_act_q || f_sq_q)) begin
						act_time_q <= now_q;
						req_q <= 8'd1;
					end
					state_q <= S_IDLE;
				end
				S_TK_NOW: state_q <= S_TK_ORD;
				S_TK_ORD: begin
					pair_q <= pair_q + 2'd1;
					state_q <= (pair_q == 2'd3) ? S_TO_ACT : S_TK_NOW;
				end
				S_TO_ACT: state_q <= S_TO_ON;
				S_TO_ON: state_q <= S_FIN;
				S_FIN: begin
					if (pend_v_q) begin
						result_valid_q <= 1'b1;
						last_q <= 1'b1;
						pwm_value_q <= pend_val_q;
						pend_v_q <= 1'b0;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_v_q)
		else $error("pending result left while idle");

	a_result_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> $past(state_q) == S_TK_ORD || $past(state_q) == S_TO_ACT ||
			$past(state_q) == S_TO_ON || $past(state_q) == S_FIN)
		else $error("result outside tick processing");

	a_last_ends_tick: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && last_q |-> state_q == S_IDLE)
		else $error("last result before tick end");

	a_emit_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(fire && sched_rst))
		else $error("transition and reset in the same step");

endmodule
